// ----- hw/rtl/sfp_pkg.sv -----
// shared types and constants for the sample flatten and pack block
// no dependencies; every other rtl file refers to this package by scoped name
`default_nettype none

package sfp_pkg;

    localparam int MAX_COLORS = 4;
    localparam int CNT_W      = $clog2(MAX_COLORS + 1);
    localparam int IDX_W      = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;

    // both queues hold a power-of-two number of entries so pointers wrap on their own
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic [7:0] BYTE_MAX  = 8'hFF;
    localparam logic [3:0] FREE_FULL = 4'd8;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_EOL    = 2'd1,
        ACT_EOI    = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_COLOR_COUNT = 2'd0,
        REG_HAS_ALPHA   = 2'd1,
        REG_EXTRA_COUNT = 2'd2,
        REG_BPC         = 2'd3
    } t_reg_idx;

    typedef enum logic {
        CMD_VALUES = 1'b0,
        CMD_FLUSH  = 1'b1
    } t_cmd_op;

    typedef enum logic [1:0] {
        BK_RUN = 2'b01,
        BK_END = 2'b10
    } t_back_state;

    typedef struct packed {
        logic [2:0] color_count;
        logic       has_alpha;
        logic [3:0] extra_count;
        logic [3:0] bpc;
    } t_cfg;

    // one command from the front: a run of values to pack, or a flush request
    typedef struct packed {
        t_cmd_op                       op;
        logic [CNT_W-1:0]              count;
        logic [MAX_COLORS-1:0][7:0]    vals;
    } t_cmd;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_res;

endpackage

`default_nettype wire

// ----- hw/rtl/sfp_front.sv -----
// front end: component removal, alpha hold and flatten, command build
// depends on sfp_pkg
`default_nettype none

module sfp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sfp_pkg::t_cfg i_cfg,
    input  wire logic          i_accept,
    input  wire logic [1:0]    i_action,
    input  wire logic [7:0]    i_sample,
    output sfp_pkg::t_cmd      o_cmd,
    output logic               o_cmd_push
);

    // removal position reaches 19 with four colors, alpha and fifteen extras
    logic [4:0]                   r_removal_pos, n_removal_pos;
    logic [sfp_pkg::CNT_W-1:0]    r_alpha_pos, n_alpha_pos;
    logic [7:0]                   r_hold [sfp_pkg::MAX_COLORS];

    logic [sfp_pkg::CNT_W-1:0]    w_ceff;
    logic [3:0]                   w_keep;
    logic [4:0]                   w_total;
    logic [4:0]                   w_rpos_inc;
    logic                         w_pass;
    logic [7:0]                   w_adjust;
    logic [8:0]                   w_sum;
    logic                         w_hold_we;

    always_comb begin
        if ({1'b0, i_cfg.color_count} > 4'(sfp_pkg::MAX_COLORS)) begin
            w_ceff = sfp_pkg::CNT_W'(sfp_pkg::MAX_COLORS);
        end else begin
            w_ceff = sfp_pkg::CNT_W'(i_cfg.color_count);
        end
        w_keep     = 4'(w_ceff) + 4'(i_cfg.has_alpha);
        w_total    = {1'b0, w_keep} + {1'b0, i_cfg.extra_count};
        w_rpos_inc = r_removal_pos + 5'd1;
        w_pass     = (i_cfg.extra_count == 4'd0) || (r_removal_pos < {1'b0, w_keep});
        w_adjust   = sfp_pkg::BYTE_MAX - i_sample;
        w_sum      = '0;

        n_removal_pos = r_removal_pos;
        n_alpha_pos   = r_alpha_pos;
        w_hold_we     = 1'b0;
        o_cmd_push    = 1'b0;
        o_cmd.op      = sfp_pkg::CMD_VALUES;
        o_cmd.count   = sfp_pkg::CNT_W'(1);
        o_cmd.vals    = '0;
        o_cmd.vals[0] = i_sample;

        case (sfp_pkg::t_action'(i_action))
            sfp_pkg::ACT_SAMPLE: begin
                if (i_cfg.extra_count != 4'd0) begin
                    n_removal_pos = (w_rpos_inc >= w_total) ? 5'd0 : w_rpos_inc;
                end
                if (w_pass) begin
                    if (!i_cfg.has_alpha) begin
                        o_cmd_push = 1'b1;
                    end else if (r_alpha_pos >= w_ceff) begin
                        // alpha byte: flatten the held colors onto white
                        for (int i = 0; i < sfp_pkg::MAX_COLORS; i++) begin
                            w_sum = {1'b0, r_hold[i]} + {1'b0, w_adjust};
                            o_cmd.vals[i] = (w_sum >= {1'b0, sfp_pkg::BYTE_MAX}) ?
                                            sfp_pkg::BYTE_MAX : w_sum[7:0];
                        end
                        o_cmd.count = w_ceff;
                        o_cmd_push  = (w_ceff != '0);
                        n_alpha_pos = '0;
                    end else begin
                        w_hold_we   = 1'b1;
                        n_alpha_pos = r_alpha_pos + sfp_pkg::CNT_W'(1);
                    end
                end
            end
            sfp_pkg::ACT_EOL: begin
                n_removal_pos = 5'd0;
                n_alpha_pos   = '0;
                o_cmd.op      = sfp_pkg::CMD_FLUSH;
                o_cmd_push    = 1'b1;
            end
            sfp_pkg::ACT_EOI: begin
                o_cmd.op   = sfp_pkg::CMD_FLUSH;
                o_cmd_push = 1'b1;
            end
            default: begin
                o_cmd_push = 1'b0;
            end
        endcase

        if (!i_accept) begin
            n_removal_pos = r_removal_pos;
            n_alpha_pos   = r_alpha_pos;
            w_hold_we     = 1'b0;
            o_cmd_push    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_removal_pos <= 5'd0;
            r_alpha_pos   <= '0;
        end else begin
            r_removal_pos <= n_removal_pos;
            r_alpha_pos   <= n_alpha_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hold_we) begin
            r_hold[r_alpha_pos[sfp_pkg::IDX_W-1:0]] <= i_sample;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sfp_cmd_queue.sv -----
// command queue between front end and packer
// depends on sfp_pkg
`default_nettype none

module sfp_cmd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sfp_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output sfp_pkg::t_cmd      o_head,
    output logic               o_empty,
    output logic               o_full
);

    sfp_pkg::t_cmd                r_mem [sfp_pkg::CMD_DEPTH];
    logic [sfp_pkg::CMD_PTR_W-1:0] r_wptr, r_rptr;
    logic [sfp_pkg::CMD_CNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == sfp_pkg::CMD_CNT_W'(sfp_pkg::CMD_DEPTH));
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + sfp_pkg::CMD_PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + sfp_pkg::CMD_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + sfp_pkg::CMD_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - sfp_pkg::CMD_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sfp_back.sv -----
// back end: sub-byte packer and run tagging, one value per cycle
// while the result queue has room, bar the end step; depends on sfp_pkg
`default_nettype none

module sfp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [3:0]    i_bpc,
    input  wire sfp_pkg::t_cmd i_head,
    input  wire logic          i_cmd_empty,
    output logic               o_cmd_pop,
    input  wire logic          i_res_full,
    output logic               o_res_push,
    output sfp_pkg::t_res      o_res
);

    sfp_pkg::t_back_state      r_state, n_state;
    logic [sfp_pkg::CNT_W-1:0] r_idx, n_idx;
    logic [3:0]                r_free, n_free;
    logic [7:0]                r_packed, n_packed;
    logic                      r_stg_vld, n_stg_vld;
    logic [7:0]                r_stg_byte, n_stg_byte;

    logic       w_pk_on;
    logic [7:0] w_val, w_vm;
    logic [3:0] w_shift;
    logic [3:0] w_spill;
    logic [3:0] w_left;
    logic       v_emit;
    logic [7:0] v_byte, v_packed;
    logic [3:0] v_free;
    logic       w_is_last;

    function automatic logic [3:0] FREE_MINUS(input logic [3:0] spill);
        FREE_MINUS = sfp_pkg::FREE_FULL - spill;
    endfunction

    // packing step for the current value
    always_comb begin
        w_pk_on  = (i_bpc != 4'd0) && !i_bpc[3];
        w_val    = i_head.vals[r_idx[sfp_pkg::IDX_W-1:0]];
        w_vm     = w_val & ~(8'hFF << i_bpc[2:0]);
        w_shift  = r_free - i_bpc;
        w_spill  = i_bpc - r_free;
        w_left   = FREE_MINUS(w_spill);
        v_emit   = 1'b1;
        v_byte   = w_val;
        v_packed = r_packed;
        v_free   = r_free;
        if (w_pk_on) begin
            if (r_free >= i_bpc) begin
                v_byte   = r_packed | (w_vm << w_shift[2:0]);
                v_free   = w_shift;
                v_packed = v_byte;
                v_emit   = (w_shift == 4'd0);
                if (w_shift == 4'd0) begin
                    v_free   = sfp_pkg::FREE_FULL;
                    v_packed = 8'd0;
                end
            end else begin
                // value straddles the byte boundary
                v_byte   = r_packed | (w_vm >> w_spill[2:0]);
                v_packed = w_vm << w_left[2:0];
                v_free   = w_left;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_free     = r_free;
        n_packed   = r_packed;
        n_stg_vld  = r_stg_vld;
        n_stg_byte = r_stg_byte;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res.data = r_stg_byte;
        o_res.last = 1'b0;
        w_is_last  = (r_idx == (i_head.count - sfp_pkg::CNT_W'(1)));

        case (r_state)
            sfp_pkg::BK_RUN: begin
                if (!i_cmd_empty) begin
                    case (i_head.op)
                        sfp_pkg::CMD_FLUSH: begin
                            if (w_pk_on && (r_free != sfp_pkg::FREE_FULL)) begin
                                o_res_push = 1'b1;
                                o_res.data = r_packed;
                                o_res.last = 1'b1;
                                n_free     = sfp_pkg::FREE_FULL;
                                n_packed   = 8'd0;
                            end
                            o_cmd_pop = 1'b1;
                        end
                        sfp_pkg::CMD_VALUES: begin
                            n_free   = v_free;
                            n_packed = v_packed;
                            if (v_emit) begin
                                if (r_stg_vld) begin
                                    o_res_push = 1'b1;
                                end
                                if (w_is_last && !r_stg_vld) begin
                                    o_res_push = 1'b1;
                                    o_res.data = v_byte;
                                    o_res.last = 1'b1;
                                end else begin
                                    n_stg_vld  = 1'b1;
                                    n_stg_byte = v_byte;
                                end
                            end else if (w_is_last && r_stg_vld) begin
                                o_res_push = 1'b1;
                                o_res.last = 1'b1;
                                n_stg_vld  = 1'b0;
                            end
                            if (w_is_last) begin
                                o_cmd_pop = 1'b1;
                                n_idx     = '0;
                                if (v_emit && r_stg_vld) begin
                                    n_state = sfp_pkg::BK_END;
                                end
                            end else begin
                                n_idx = r_idx + sfp_pkg::CNT_W'(1);
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            sfp_pkg::BK_END: begin
                o_res_push = 1'b1;
                o_res.last = 1'b1;
                n_stg_vld  = 1'b0;
                n_state    = sfp_pkg::BK_RUN;
            end
            default: begin
                n_state = sfp_pkg::BK_RUN;
            end
        endcase

        // result queue full: hold everything and drop the push and the pop
        if (o_res_push && i_res_full) begin
            n_state    = r_state;
            n_idx      = r_idx;
            n_free     = r_free;
            n_packed   = r_packed;
            n_stg_vld  = r_stg_vld;
            n_stg_byte = r_stg_byte;
            o_cmd_pop  = 1'b0;
            o_res_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sfp_pkg::BK_RUN;
            r_idx     <= '0;
            r_free    <= sfp_pkg::FREE_FULL;
            r_packed  <= 8'd0;
            r_stg_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_free    <= n_free;
            r_packed  <= n_packed;
            r_stg_vld <= n_stg_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stg_byte <= n_stg_byte;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sfp_res_queue.sv -----
// result queue feeding the output side
// depends on sfp_pkg
`default_nettype none

module sfp_res_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sfp_pkg::t_res i_res,
    input  wire logic          i_pop,
    output sfp_pkg::t_res      o_head,
    output logic               o_empty,
    output logic               o_full
);

    sfp_pkg::t_res                 r_mem [sfp_pkg::RES_DEPTH];
    logic [sfp_pkg::RES_PTR_W-1:0] r_wptr, r_rptr;
    logic [sfp_pkg::RES_CNT_W-1:0] r_cnt;
    logic                          w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == sfp_pkg::RES_CNT_W'(sfp_pkg::RES_DEPTH));
    assign o_head  = r_mem[r_rptr];
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + sfp_pkg::RES_PTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + sfp_pkg::RES_PTR_W'(1);
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + sfp_pkg::RES_CNT_W'(1);
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - sfp_pkg::RES_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_res;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sample_flatten_and_pack.sv -----
// top level of the sample flatten and pack block: config registers, front end,
// command queue, packer and result queue; depends on sfp_pkg and all sfp_ modules
// usage
//   input channel: push/full, one item (i_action, i_sample) per transfer
//   result channel: empty/pop; the oldest result sits on o_out_byte and
//     o_last_of_run while empty is low, o_last_of_run marks the final result
//     of the item that caused it
//   config: apb-style writes at byte address 4*index, pready tied high,
//     reads return the register value; write only while the block is idle
// timing
//   an item is classified in its accept cycle and lands in a 4-entry command
//   queue; the packer works on the queue head and may hold a finished byte
//   in its staging register before the byte enters the result queue
//   throughput: one item per cycle for items with at most one value while the
//   result queue has room; an alpha byte holds the packer for each of its colors,
//   plus an end step when its last value and an earlier one both complete a byte
// reset (synchronous, active low) restores the register defaults, clears
// both positions and the packer, and empties both queues
// a stalled receiver fills the 4-entry result queue, the packer then holds,
// the command queue fills and full rises on the input side
`default_nettype none

module sample_flatten_and_pack (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_sample,
    // result channel
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_run,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    sfp_pkg::t_cfg r_cfg;
    logic          w_cfg_we;
    logic          w_accept;

    sfp_pkg::t_cmd w_cmd, w_head;
    logic          w_cmd_push, w_cmd_pop, w_cmd_empty, w_cmd_full;

    sfp_pkg::t_res w_res, w_res_head;
    logic          w_res_push, w_res_full;

    // config registers, written on the apb access phase
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_count <= 3'd3;
            r_cfg.has_alpha   <= 1'b0;
            r_cfg.extra_count <= 4'd0;
            r_cfg.bpc         <= 4'd8;
        end else if (w_cfg_we) begin
            case (sfp_pkg::t_reg_idx'(paddr[3:2]))
                sfp_pkg::REG_COLOR_COUNT: r_cfg.color_count <= pwdata[2:0];
                sfp_pkg::REG_HAS_ALPHA:   r_cfg.has_alpha   <= pwdata[0];
                sfp_pkg::REG_EXTRA_COUNT: r_cfg.extra_count <= pwdata[3:0];
                sfp_pkg::REG_BPC:         r_cfg.bpc         <= pwdata[3:0];
                default:                  r_cfg             <= r_cfg;
            endcase
        end
    end

    // register readback, zero extended
    always_comb begin
        case (sfp_pkg::t_reg_idx'(paddr[3:2]))
            sfp_pkg::REG_COLOR_COUNT: prdata = {29'd0, r_cfg.color_count};
            sfp_pkg::REG_HAS_ALPHA:   prdata = {31'd0, r_cfg.has_alpha};
            sfp_pkg::REG_EXTRA_COUNT: prdata = {28'd0, r_cfg.extra_count};
            sfp_pkg::REG_BPC:         prdata = {28'd0, r_cfg.bpc};
            default:                  prdata = 32'd0;
        endcase
    end

    // input side: the front end takes an item whenever the command queue has room
    assign full     = w_cmd_full;
    assign w_accept = push && !full;

    sfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_accept   (w_accept),
        .i_action   (i_action),
        .i_sample   (i_sample),
        .o_cmd      (w_cmd),
        .o_cmd_push (w_cmd_push)
    );

    sfp_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_cmd_pop),
        .o_head  (w_head),
        .o_empty (w_cmd_empty),
        .o_full  (w_cmd_full)
    );

    // back end: packs values and tags the last result of each run
    sfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bpc       (r_cfg.bpc),
        .i_head      (w_head),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    sfp_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .i_pop   (pop),
        .o_head  (w_res_head),
        .o_empty (empty),
        .o_full  (w_res_full)
    );

    assign o_out_byte    = w_res_head.data;
    assign o_last_of_run = w_res_head.last;

    // checks
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result queue written while full");

    a_cmd_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_push |-> !w_cmd_full)
        else $error("command queue written while full");

    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_cmd_empty)
        else $error("command queue popped while empty");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

endmodule

`default_nettype wire

// ----- sim/sample_flatten_and_pack_tb.sv -----
// self-checking testbench for sample_flatten_and_pack: directed and random item streams,
// apb register writes, back pressure; depends on sfp_pkg and the sample_flatten_and_pack rtl
`default_nettype none

module sample_flatten_and_pack_tb;

    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_action;
    logic [7:0]  i_sample;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_of_run;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sample_flatten_and_pack DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_action      (i_action),
        .i_sample      (i_sample),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // idle and stall rates in percent per cycle, set by the back pressure and random tests
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    // long receiver hold-off, counted down by the pop driver
    int unsigned hold_off_cycles;
    int unsigned mismatch_count;

    // bytes still owed by the block, oldest first
    sfp_pkg::t_res pending_bytes[$];

    // ------------------------------------------------------------------
    // predictor: own copy of the format registers and the pipeline state
    // ------------------------------------------------------------------
    logic [2:0]  fmt_colors;
    logic        fmt_alpha;
    logic [3:0]  fmt_extra;
    logic [3:0]  fmt_bpc;
    int unsigned drop_pos;       // position inside the pixel for extra removal
    int unsigned color_pos;      // colors held so far while waiting for alpha
    logic [7:0]  held_color [0:sfp_pkg::MAX_COLORS-1];
    int unsigned free_bits;      // unused bits left in the byte being packed
    logic [7:0]  partial_byte;
    logic [7:0]  run_bytes[$];   // bytes caused by the current item

    function automatic int unsigned colors_used();
        return (fmt_colors > sfp_pkg::MAX_COLORS) ? sfp_pkg::MAX_COLORS : fmt_colors;
    endfunction

    function automatic bit packing_on();
        return (fmt_bpc >= 1) && (fmt_bpc < 8);
    endfunction

    function automatic void flush_partial();
        run_bytes    = {run_bytes, partial_byte};
        free_bits    = 8;
        partial_byte = 8'h00;
    endfunction

    // msb-first packing of one value; a value may straddle two bytes
    function automatic void pack_value(input int unsigned value);
        int unsigned width;
        int unsigned spill;
        width = fmt_bpc;
        if (!packing_on()) begin
            run_bytes = {run_bytes, value[7:0]};
            return;
        end
        value &= (32'd1 << width) - 1;
        if (free_bits > 8) free_bits = 8;
        if (free_bits >= width) begin
            partial_byte |= 8'(value << (free_bits - width));
            free_bits    -= width;
        end else begin
            spill = width - free_bits;
            partial_byte |= 8'(value >> spill);
            flush_partial();
            partial_byte |= 8'(value << (8 - spill));
            free_bits     = 8 - spill;
        end
        if (free_bits == 0) flush_partial();
    endfunction

    // works out the bytes that one accepted item causes
    task automatic predict_bytes(input sfp_pkg::t_action act, input logic [7:0] smp);
        int unsigned   keep;
        int unsigned   ncol;
        int unsigned   lift;
        int unsigned   sum;
        bit            kept;
        sfp_pkg::t_res res;
        run_bytes.delete();
        case (act)
            sfp_pkg::ACT_SAMPLE: begin
                ncol = colors_used();
                keep = ncol + fmt_alpha;
                // extras trail the kept components; no extras passes every byte
                kept = (fmt_extra == 0) || (drop_pos < keep);
                if (fmt_extra != 0) begin
                    drop_pos++;
                    if (drop_pos >= keep + fmt_extra) drop_pos = 0;
                end
                if (kept && !fmt_alpha) begin
                    pack_value(smp);
                end else if (kept && color_pos >= ncol) begin
                    // alpha byte: flatten held colors onto white, saturating
                    lift = 255 - smp;
                    for (int i = 0; i < ncol; i++) begin
                        sum = held_color[i] + lift;
                        pack_value((sum >= 255) ? 255 : sum);
                    end
                    color_pos = 0;
                end else if (kept) begin
                    held_color[color_pos] = smp;
                    color_pos++;
                end
            end
            sfp_pkg::ACT_EOL: begin
                drop_pos  = 0;
                color_pos = 0;
                if (packing_on() && free_bits != 8) flush_partial();
            end
            sfp_pkg::ACT_EOI: begin
                if (packing_on() && free_bits != 8) flush_partial();
            end
            default: ;
        endcase
        while (run_bytes.size() > 4) void'(run_bytes.pop_back());
        foreach (run_bytes[k]) begin
            res.data = run_bytes[k];
            res.last = (k == run_bytes.size() - 1);
            pending_bytes = {pending_bytes, res};
        end
    endtask

    // ------------------------------------------------------------------
    // result side: pop driver and checker
    // ------------------------------------------------------------------

    // pop changes at the falling edge; a hold-off overrides the random stall
    always @(negedge i_clk) begin
        if (hold_off_cycles != 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // every transfer on the result side is compared with the oldest expected byte
    always @(posedge i_clk) begin : check_results
        sfp_pkg::t_res want;
        if (i_rst_n && pop && !empty) begin
            if (pending_bytes.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: byte %h last %b at %0t",
                             o_out_byte, o_last_of_run, $time);
                mismatch_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_byte !== want.data || o_last_of_run !== want.last) begin
                    if (mismatch_count < 10)
                        $display("mismatch: expected byte %h last %b, got byte %h last %b at %0t",
                                 want.data, want.last, o_out_byte, o_last_of_run, $time);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offers one item after a random gap and holds it until the transfer;
    // starts and ends at a falling edge
    task automatic send_item(input sfp_pkg::t_action act, input logic [7:0] smp);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push     = 1'b1;
        i_action = act;
        i_sample = smp;
        do @(posedge i_clk); while (full);
        predict_bytes(act, smp);
        @(negedge i_clk);
        push = 1'b0;
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input sfp_pkg::t_reg_idx idx, input logic [3:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = 32'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            sfp_pkg::REG_COLOR_COUNT: fmt_colors = value[2:0];
            sfp_pkg::REG_HAS_ALPHA:   fmt_alpha  = value[0];
            sfp_pkg::REG_EXTRA_COUNT: fmt_extra  = value;
            sfp_pkg::REG_BPC:         fmt_bpc    = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_format(input logic [2:0] colors, input logic alpha,
                                input logic [3:0] extra, input logic [3:0] bpc);
        write_reg(sfp_pkg::REG_COLOR_COUNT, {1'b0, colors});
        write_reg(sfp_pkg::REG_HAS_ALPHA, {3'b000, alpha});
        write_reg(sfp_pkg::REG_EXTRA_COUNT, extra);
        write_reg(sfp_pkg::REG_BPC, bpc);
    endtask

    // waits until every owed byte has come out, then lets items that cause
    // no byte leave the command queue and the packer
    task automatic wait_drained();
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset format: three colors, no alpha, whole bytes; flushes do nothing
    task automatic test_passthrough();
        send_item(sfp_pkg::ACT_SAMPLE, 8'h00);
        send_item(sfp_pkg::ACT_SAMPLE, 8'hFF);
        send_item(sfp_pkg::ACT_SAMPLE, 8'hA5);
        send_item(sfp_pkg::ACT_SAMPLE, 8'h5A);
        send_item(sfp_pkg::ACT_EOI, 8'h00);
        send_item(sfp_pkg::ACT_EOL, 8'hFF);
        send_item(sfp_pkg::ACT_NONE, 8'h3C);
    endtask

    // color count above the maximum acts as four; two extras are dropped
    task automatic test_alpha_flatten();
        wait_drained();
        apply_format(3'd7, 1'b1, 4'd2, 4'd8);
        send_item(sfp_pkg::ACT_SAMPLE, 8'h00);
        send_item(sfp_pkg::ACT_SAMPLE, 8'hFF);
        send_item(sfp_pkg::ACT_SAMPLE, 8'h7F);
        send_item(sfp_pkg::ACT_SAMPLE, 8'h80);
        send_item(sfp_pkg::ACT_SAMPLE, 8'h80);
        send_item(sfp_pkg::ACT_SAMPLE, 8'h11);
        send_item(sfp_pkg::ACT_SAMPLE, 8'h22);
        send_item(sfp_pkg::ACT_EOL, 8'h00);
    endtask

    // 3-bit samples straddle a byte boundary; end of scanline flushes the rest
    task automatic test_packing();
        wait_drained();
        apply_format(3'd1, 1'b0, 4'd0, 4'd3);
        send_item(sfp_pkg::ACT_SAMPLE, 8'hFF);
        send_item(sfp_pkg::ACT_SAMPLE, 8'h00);
        send_item(sfp_pkg::ACT_SAMPLE, 8'hFF);
        send_item(sfp_pkg::ACT_EOL, 8'h00);
    endtask

    // zero colors with alpha: the alpha stage has nothing to send
    task automatic test_zero_colors();
        wait_drained();
        apply_format(3'd0, 1'b1, 4'd1, 4'd8);
        send_item(sfp_pkg::ACT_SAMPLE, 8'h42);
        send_item(sfp_pkg::ACT_SAMPLE, 8'hC3);
    endtask

    // widths of zero and above eight pass samples through whole
    task automatic test_odd_width();
        wait_drained();
        apply_format(3'd3, 1'b0, 4'd0, 4'd0);
        send_item(sfp_pkg::ACT_SAMPLE, 8'h5A);
        send_item(sfp_pkg::ACT_EOI, 8'h00);
        wait_drained();
        write_reg(sfp_pkg::REG_BPC, 4'd15);
        send_item(sfp_pkg::ACT_SAMPLE, 8'hC6);
    endtask

    // receiver holds off while alpha pixels keep coming: the result queue
    // fills, the packer stalls and full rises on the input side
    task automatic test_backpressure();
        wait_drained();
        apply_format(3'd4, 1'b1, 4'd0, 4'd8);
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        hold_off_cycles = 150;
        repeat (30) send_item(sfp_pkg::ACT_SAMPLE, pick_sample());
    endtask

    // mostly well-formed pixel rows with random content, plus stray flushes,
    // broken rows and ignored actions; the format stays fixed within one stream
    task automatic run_random_items(input int unsigned count);
        int unsigned pix_total;
        int unsigned pos;
        int unsigned sent;
        int unsigned r;
        pix_total = colors_used() + fmt_alpha + fmt_extra;
        pos  = 0;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_item(sfp_pkg::ACT_NONE, pick_sample());
            end else if (r < 7) begin
                send_item(sfp_pkg::ACT_EOI, pick_sample());
                sent++;
            end else if (r < 10 || (pos == 0 && r < 22)) begin
                send_item(sfp_pkg::ACT_EOL, pick_sample());
                pos = 0;
                sent++;
            end else begin
                send_item(sfp_pkg::ACT_SAMPLE, pick_sample());
                pos++;
                if (pos >= pix_total) pos = 0;
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        int unsigned src_tab  [4] = '{0, 81, 0, 20};
        int unsigned sink_tab [4] = '{0, 0, 81, 20};
        logic [2:0]  colors;
        logic        alpha;
        logic [3:0]  extra;
        logic [3:0]  bpc;
        for (int phase = 0; phase < 4; phase++) begin
            for (int setting = 0; setting < 2; setting++) begin
                wait_drained();
                src_idle_pct   = src_tab[phase];
                sink_stall_pct = sink_tab[phase];
                colors = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                    : 3'($urandom_range(1, 4));
                alpha  = 1'($urandom_range(0, 1));
                extra  = ($urandom_range(0, 1) == 0) ? 4'd0
                       : (($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                      : 4'($urandom_range(1, 3)));
                bpc    = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(1, 8));
                // pin a few settings to the extremes
                if (phase == 0 && setting == 1) begin
                    colors = 3'd4; alpha = 1'b1; extra = 4'd15; bpc = 4'd1;
                end else if (phase == 2 && setting == 0) begin
                    colors = 3'd1; alpha = 1'b0; extra = 4'd8; bpc = 4'd7;
                end else if (phase == 3 && setting == 1) begin
                    colors = 3'd4; alpha = 1'b1; extra = 4'd0; bpc = 4'd1;
                end
                apply_format(colors, alpha, extra, bpc);
                run_random_items(10);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        push            = 1'b0;
        i_action        = sfp_pkg::ACT_SAMPLE;
        i_sample        = 8'h00;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        hold_off_cycles = 0;
        mismatch_count  = 0;
        // predictor starts from the reset state of the block
        fmt_colors   = 3'd3;
        fmt_alpha    = 1'b0;
        fmt_extra    = 4'd0;
        fmt_bpc      = 4'd8;
        drop_pos     = 0;
        color_pos    = 0;
        free_bits    = 8;
        partial_byte = 8'h00;
        foreach (held_color[i]) held_color[i] = 8'h00;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_passthrough();
        test_alpha_flatten();
        test_packing();
        test_zero_colors();
        test_odd_width();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
